### src/bc45_pkg.sv
package bc45_pkg;

   localparam logic [16:0] ZSQ_FULL     = 17'd65025;
   localparam logic [11:0] RECIP7       = 12'd2341;
   localparam logic [11:0] RECIP5       = 12'd3277;
   localparam int          RECIP_SHIFT  = 14;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
   localparam logic [7:0]  PAL_ZERO     = 8'd0;
   localparam logic [7:0]  PAL_FULL     = 8'd255;
   localparam logic [3:0]  LAST_TEXEL   = 4'd15;

   typedef struct packed {
      logic [7:0]  e0;
      logic [7:0]  e1;
      logic        wide;
      logic [47:0] idx;
   } half_desc_type;

   typedef struct packed {
      half_desc_type red;
      half_desc_type green;
      logic          normal;
   } block_desc_type;

   typedef struct packed {
      logic [10:0] num;
      logic [7:0]  direct;
      logic        use_direct;
      logic        div7;
   } pal_sel_type;

   typedef struct packed {
      logic [1:0] col;
      logic [1:0] row;
      logic       last;
      logic       normal;
      logic [7:0] red;
      logic [7:0] green;
   } texel_type;

   function automatic half_desc_type classify_half(logic [63:0] half);
      half_desc_type d;
      d.e0   = half[7:0];
      d.e1   = half[15:8];
      d.wide = (half[7:0] > half[15:8]);
      d.idx  = half[63:16];
      return d;
   endfunction

   function automatic pal_sel_type pal_select(half_desc_type h, logic [2:0] k);
      pal_sel_type s;
      logic [2:0]  w0;
      logic [2:0]  w1;
      s.direct     = h.e0;
      s.use_direct = 1'b1;
      s.div7       = h.wide;
      w0           = 3'd0;
      w1           = 3'd0;
      if (k == 3'd0) begin
         s.direct = h.e0;
      end else if (k == 3'd1) begin
         s.direct = h.e1;
      end else if (h.wide) begin
         w0           = 3'(4'd8 - {1'b0, k});
         w1           = 3'(k - 3'd1);
         s.use_direct = 1'b0;
      end else if (k < 3'd6) begin
         w0           = 3'(4'd6 - {1'b0, k});
         w1           = 3'(k - 3'd1);
         s.use_direct = 1'b0;
      end else if (k == 3'd6) begin
         s.direct = PAL_ZERO;
      end else begin
         s.direct = PAL_FULL;
      end
      s.num = ({8'd0, w0} * {3'd0, h.e0}) + ({8'd0, w1} * {3'd0, h.e1});
      return s;
   endfunction

   // floor(num/7) or floor(num/5) by reciprocal; exact for num <= 1785
   function automatic logic [7:0] pal_finish(pal_sel_type s);
      logic [22:0] prod;
      prod = {12'd0, s.num} * {11'd0, (s.div7 ? RECIP7 : RECIP5)};
      return s.use_direct ? s.direct : prod[RECIP_SHIFT +: 8];
   endfunction

endpackage

### src/bc4_bc5_block_decoder.sv
// BC4/BC5 4x4 texture block decoder.
// Input channel (req_): one transaction carries a compressed block, red_half
// and green_half (green_half is read only in normal mode). Output channel
// (rsp_): sixteen transactions per block, one texel each in raster order,
// rsp_last_texel set on the sixteenth. Both channels use valid/stall.
// Config: csr_write_enable with csr_write_data selects normal mode (1, BC5
// with z rebuilt) or greyscale (0, BC4); write only while idle.
// Throughput: one texel per cycle while rsp_ is not stalled, set by the back end.
// A two-entry block queue holds the block being decoded plus one waiting
// block, so the front accepts one block ahead.
// Pipeline: the queue is written at the accepting edge; each texel then passes
// palette select, divide, z setup, the 8-stage square root and the output
// register, which drives rsp_valid.
// Reset: synchronous, clears the queue, pipeline and mode (greyscale).
// A stalled rsp_ holds its transaction and freezes the whole back pipeline;
// the front keeps accepting until the queue is full, then raises req_stall.
module bc4_bc5_block_decoder
   import bc45_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_red_half,
   input  logic [63:0] req_green_half,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_texel_col,
   output logic [1:0]  rsp_texel_row,
   output logic [7:0]  rsp_red_value,
   output logic [7:0]  rsp_green_value,
   output logic [7:0]  rsp_blue_value,
   output logic [7:0]  rsp_alpha_value,
   output logic        rsp_last_texel
);

   logic           push;
   block_desc_type push_desc;
   logic           queue_full;
   logic           pop;
   logic           desc_valid;
   block_desc_type desc;

   bc45_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_half     (req_red_half),
      .req_green_half   (req_green_half),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_desc        (push_desc)
   );

   bc45_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (desc_valid),
      .pop_desc  (desc)
   );

   bc45_back u_back (
      .clock           (clock),
      .reset           (reset),
      .desc_valid      (desc_valid),
      .desc            (desc),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_texel_col   (rsp_texel_col),
      .rsp_texel_row   (rsp_texel_row),
      .rsp_red_value   (rsp_red_value),
      .rsp_green_value (rsp_green_value),
      .rsp_blue_value  (rsp_blue_value),
      .rsp_alpha_value (rsp_alpha_value),
      .rsp_last_texel  (rsp_last_texel)
   );

endmodule

### src/bc45_front.sv
module bc45_front
   import bc45_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [63:0]    req_red_half,
   input  logic [63:0]    req_green_half,
   input  logic           csr_write_enable,
   input  logic           csr_write_data,
   input  logic           queue_full,
   output logic           push,
   output block_desc_type push_desc
);

   logic normal_mode_ff;
   logic normal_mode_in;

   always_comb begin
      normal_mode_in = csr_write_enable ? csr_write_data : normal_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_mode_ff <= 1'b0;
      end else begin
         normal_mode_ff <= normal_mode_in;
      end
   end

   assign req_stall        = queue_full;
   assign push             = req_valid && !queue_full;
   assign push_desc.red    = classify_half(req_red_half);
   assign push_desc.green  = classify_half(req_green_half);
   assign push_desc.normal = normal_mode_ff;

endmodule

### src/bc45_queue.sv
module bc45_queue
   import bc45_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  block_desc_type push_desc,
   output logic           full,
   input  logic           pop,
   output logic           not_empty,
   output block_desc_type pop_desc
);

   block_desc_type entry_ff [2];
   logic           wr_ptr_ff;
   logic           wr_ptr_in;
   logic           rd_ptr_ff;
   logic           rd_ptr_in;
   logic [1:0]     count_ff;
   logic [1:0]     count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### src/bc45_isqrt.sv
module bc45_isqrt
   import bc45_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  texel_type   in_tag,
   input  logic [15:0] in_value,
   output logic        out_valid,
   output texel_type   out_tag,
   output logic [7:0]  out_root
);

   // one root bit per stage, two radicand bits consumed per stage
   logic        valid_ff [8];
   texel_type   tag_ff   [8];
   logic [10:0] rem_ff   [8];
   logic [7:0]  root_ff  [8];
   logic [15:0] val_ff   [8];

   logic [10:0] rem_in   [8];
   logic [7:0]  root_in  [8];

   genvar j;
   generate
      for (j = 0; j < 8; j++) begin : g_stage
         logic [10:0] prev_rem;
         logic [7:0]  prev_root;
         logic [15:0] prev_val;
         logic        prev_valid;
         texel_type   prev_tag;
         logic [10:0] shifted;
         logic [10:0] trial;

         if (j == 0) begin : g_first
            assign prev_rem   = 11'd0;
            assign prev_root  = 8'd0;
            assign prev_val   = in_value;
            assign prev_valid = in_valid;
            assign prev_tag   = in_tag;
         end else begin : g_next
            assign prev_rem   = rem_ff[j-1];
            assign prev_root  = root_ff[j-1];
            assign prev_val   = val_ff[j-1];
            assign prev_valid = valid_ff[j-1];
            assign prev_tag   = tag_ff[j-1];
         end

         always_comb begin
            shifted = {prev_rem[8:0], prev_val[15:14]};
            trial   = {1'b0, prev_root, 2'b01};
            if (shifted >= trial) begin
               rem_in[j]  = shifted - trial;
               root_in[j] = {prev_root[6:0], 1'b1};
            end else begin
               rem_in[j]  = shifted;
               root_in[j] = {prev_root[6:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else if (enable) begin
               valid_ff[j] <= prev_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               tag_ff[j]  <= prev_tag;
               rem_ff[j]  <= rem_in[j];
               root_ff[j] <= root_in[j];
               val_ff[j]  <= {prev_val[13:0], 2'b00};
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[7];
   assign out_tag   = tag_ff[7];
   assign out_root  = root_ff[7];

endmodule

### src/bc45_back.sv
module bc45_back
   import bc45_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           desc_valid,
   input  block_desc_type desc,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [1:0]     rsp_texel_col,
   output logic [1:0]     rsp_texel_row,
   output logic [7:0]     rsp_red_value,
   output logic [7:0]     rsp_green_value,
   output logic [7:0]     rsp_blue_value,
   output logic [7:0]     rsp_alpha_value,
   output logic           rsp_last_texel
);

   logic        advance;
   logic        issue;
   logic [3:0]  texel_ff;
   logic [3:0]  texel_in;

   logic        a_valid_ff;
   texel_type   a_tag_ff;
   pal_sel_type a_rsel_ff;
   pal_sel_type a_gsel_ff;
   texel_type   a_tag_in;

   logic        b_valid_ff;
   texel_type   b_tag_ff;
   texel_type   b_tag_in;

   logic        c_valid_ff;
   texel_type   c_tag_ff;
   logic [15:0] c_rem_ff;
   logic [15:0] c_rem_in;

   logic signed [9:0]  red_s;
   logic signed [9:0]  green_s;
   logic signed [19:0] red_sq;
   logic signed [19:0] green_sq;
   logic signed [20:0] rem_full;

   logic        sq_valid;
   texel_type   sq_tag;
   logic [7:0]  sq_root;
   logic [8:0]  z_sum;

   logic        rsp_valid_ff;
   texel_type   rsp_tag_ff;
   logic [7:0]  rsp_blue_ff;
   logic [7:0]  rsp_blue_in;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign issue   = advance && desc_valid;
   assign pop     = issue && (texel_ff == LAST_TEXEL);

   always_comb begin
      texel_in        = issue ? texel_ff + 4'd1 : texel_ff;
      a_tag_in.col    = texel_ff[1:0];
      a_tag_in.row    = texel_ff[3:2];
      a_tag_in.last   = (texel_ff == LAST_TEXEL);
      a_tag_in.normal = desc.normal;
      a_tag_in.red    = 8'd0;
      a_tag_in.green  = 8'd0;
   end

   always_comb begin
      b_tag_in       = a_tag_ff;
      b_tag_in.red   = pal_finish(a_rsel_ff);
      b_tag_in.green = a_tag_ff.normal ? pal_finish(a_gsel_ff) : pal_finish(a_rsel_ff);
   end

   always_comb begin
      red_s    = $signed({1'b0, b_tag_ff.red, 1'b0}) - 10'sd255;
      green_s  = $signed({1'b0, b_tag_ff.green, 1'b0}) - 10'sd255;
      red_sq   = red_s * red_s;
      green_sq = green_s * green_s;
      rem_full = $signed({4'd0, ZSQ_FULL}) - 21'(red_sq) - 21'(green_sq);
      c_rem_in = (rem_full > 21'sd0) ? rem_full[15:0] : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texel_ff     <= 4'd0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         texel_ff <= texel_in;
         if (advance) begin
            a_valid_ff   <= desc_valid;
            b_valid_ff   <= a_valid_ff;
            c_valid_ff   <= b_valid_ff;
            rsp_valid_ff <= sq_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_tag_ff    <= a_tag_in;
         a_rsel_ff   <= pal_select(desc.red, desc.red.idx[3*texel_ff +: 3]);
         a_gsel_ff   <= pal_select(desc.green, desc.green.idx[3*texel_ff +: 3]);
         b_tag_ff    <= b_tag_in;
         c_tag_ff    <= b_tag_ff;
         c_rem_ff    <= c_rem_in;
         rsp_tag_ff  <= sq_tag;
         rsp_blue_ff <= rsp_blue_in;
      end
   end

   bc45_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (c_valid_ff),
      .in_tag    (c_tag_ff),
      .in_value  (c_rem_ff),
      .out_valid (sq_valid),
      .out_tag   (sq_tag),
      .out_root  (sq_root)
   );

   always_comb begin
      z_sum       = {1'b0, sq_root} + 9'd255;
      rsp_blue_in = sq_tag.normal ? z_sum[8:1] : sq_tag.red;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_texel_col   = rsp_tag_ff.col;
   assign rsp_texel_row   = rsp_tag_ff.row;
   assign rsp_red_value   = rsp_tag_ff.red;
   assign rsp_green_value = rsp_tag_ff.green;
   assign rsp_blue_value  = rsp_blue_ff;
   assign rsp_alpha_value = ALPHA_OPAQUE;
   assign rsp_last_texel  = rsp_tag_ff.last;

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tag_ff.last |-> rsp_tag_ff.col == 2'd3 && rsp_tag_ff.row == 2'd3)
      else $error("last texel not at block corner");

   a_pop_end: assert property (@(posedge clock) disable iff (reset)
      pop |=> texel_ff == 4'd0)
      else $error("block popped before sixteenth texel");

   a_grey_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tag_ff.normal |->
         rsp_blue_ff == rsp_tag_ff.red && rsp_tag_ff.green == rsp_tag_ff.red)
      else $error("greyscale texel channels differ");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(texel_ff) && $stable(a_valid_ff))
      else $error("pipeline moved under output stall");

endmodule
